// File: rtl/core/sbp_pkg.sv
// Shared types and constants for the spectrum bin post-processing block.
// No dependencies; imported by sbp_mult, sbp_iter and spectrum_bin_postprocess.
package sbp_pkg;

  // Output mode register codes
  localparam logic [2:0] MODE_MAG   = 3'd0;
  localparam logic [2:0] MODE_DB    = 3'd1;
  localparam logic [2:0] MODE_DBM   = 3'd2;
  localparam logic [2:0] MODE_PD    = 3'd3;
  localparam logic [2:0] MODE_PHASE = 3'd4;

  // Configuration register indexes
  localparam logic CFG_SAMPLE_RATE = 1'b0;
  localparam logic CFG_OUTPUT_MODE = 1'b1;

  localparam logic [17:0] FS_RESET = 18'd44100;

  // 10*log10(2) in Q20
  localparam logic [21:0] DB_COEF_Q20 = 22'd3156528;

  localparam logic signed [31:0] DB_FLOOR    = -32'sd7864320;   // -120.0
  localparam logic signed [31:0] DBM_FLOOR   = -32'sd13107200;  // -200.0
  localparam logic signed [31:0] DBM_OFFSET  = 32'sd1966080;    // 30.0
  localparam logic signed [31:0] ANG180      = 32'sd11796480;   // 180.0 deg
  localparam logic [31:0]        SAT_MAX     = 32'h7FFF_FFFF;

  localparam int CORDIC_STEPS = 24;

  // Operations of the iterative unit
  typedef enum logic [1:0] {
    OP_SQRT = 2'd0,
    OP_LOG  = 2'd1,
    OP_ATAN = 2'd2
  } iter_op_t;

  // Operand pair for the shared multiplier
  typedef struct packed {
    logic signed [32:0] a;
    logic signed [32:0] b;
  } mul_req_t;

  // atan(2^-i) in degrees, Q16.16
  function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0:  r = 32'sd2949120;
      5'd1:  r = 32'sd1740967;
      5'd2:  r = 32'sd919879;
      5'd3:  r = 32'sd466945;
      5'd4:  r = 32'sd234379;
      5'd5:  r = 32'sd117304;
      5'd6:  r = 32'sd58666;
      5'd7:  r = 32'sd29335;
      5'd8:  r = 32'sd14668;
      5'd9:  r = 32'sd7334;
      5'd10: r = 32'sd3667;
      5'd11: r = 32'sd1833;
      5'd12: r = 32'sd917;
      5'd13: r = 32'sd458;
      5'd14: r = 32'sd229;
      5'd15: r = 32'sd115;
      5'd16: r = 32'sd57;
      5'd17: r = 32'sd29;
      5'd18: r = 32'sd14;
      5'd19: r = 32'sd7;
      5'd20: r = 32'sd4;
      5'd21: r = 32'sd2;
      5'd22: r = 32'sd1;
      5'd23: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/sbp_mult.sv
// Shared registered 33x33 signed multiplier.
// Depends on sbp_pkg (mul_req_t).
module sbp_mult import sbp_pkg::*; (
  input  logic               clk,
  input  mul_req_t           req,
  output logic signed [65:0] p
);

  // Register the product
  always_ff @(posedge clk) begin
    p <= 66'($signed(req.a)) * 66'($signed(req.b));
  end

endmodule

// File: rtl/core/sbp_iter.sv
// Iterative unit: integer square root, log2 by repeated squaring and
// vectoring CORDIC for phase. Depends on sbp_pkg; uses the shared
// multiplier through mul_req / mul_p.
module sbp_iter import sbp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  iter_op_t           op,
  input  logic [63:0]        arg_a,
  input  logic signed [31:0] arg_x,
  input  logic signed [31:0] arg_y,
  input  logic signed [65:0] mul_p,
  output mul_req_t           mul_req,
  output logic               done,
  output logic [63:0]        result
);

  typedef enum logic [7:0] {
    I_IDLE  = 8'b00000001,
    I_SQRT  = 8'b00000010,
    I_LNORM = 8'b00000100,
    I_LMUL  = 8'b00001000,
    I_LSQ   = 8'b00010000,
    I_ANORM = 8'b00100000,
    I_ROT   = 8'b01000000,
    I_DONE  = 8'b10000000
  } it_state_t;

  localparam logic signed [35:0] NORM_MIN = 36'sh0_4000_0000;

  it_state_t          st;
  iter_op_t           op_r;
  logic [63:0]        w0;
  logic [63:0]        w1;
  logic [63:0]        w2;
  logic [6:0]         cnt;
  logic [5:0]         e;
  logic signed [35:0] cx;
  logic signed [35:0] cy;
  logic signed [31:0] z;

  logic [63:0]        trial;
  logic [32:0]        sq;
  logic signed [35:0] ay;
  logic signed [35:0] sx;
  logic signed [35:0] sy;
  logic signed [6:0]  lg_int;
  logic signed [35:0] ext_x;
  logic signed [35:0] ext_y;

  // Step datapath
  always_comb begin
    trial  = w1 + w2;
    sq     = mul_p[63:31];
    ay     = cy[35] ? -cy : cy;
    sx     = cx >>> cnt[4:0];
    sy     = cy >>> cnt[4:0];
    lg_int = $signed({1'b0, e}) - 7'sd32;
    ext_x  = {{4{arg_x[31]}}, arg_x};
    ext_y  = {{4{arg_y[31]}}, arg_y};
  end

  // Square the log mantissa
  assign mul_req.a = {1'b0, w1[31:0]};
  assign mul_req.b = {1'b0, w1[31:0]};

  assign done = (st == I_DONE);

  // Select the result of the finished operation
  always_comb begin
    case (op_r)
      OP_SQRT: result = w1;
      OP_LOG:  result = {{25{lg_int[6]}}, lg_int, w2[31:0]};
      OP_ATAN: result = {{32{z[31]}}, z};
      default: result = w1;
    endcase
  end

  // Sequence the steps; a new start is taken only in idle
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= I_IDLE;
      op_r <= OP_SQRT;
    end else begin
      case (st)
        I_IDLE: if (start) begin
          op_r <= op;
          cnt  <= 7'd0;
          case (op)
            OP_SQRT: begin
              w0 <= arg_a;
              w1 <= 64'd0;
              w2 <= 64'h4000_0000_0000_0000;
              st <= I_SQRT;
            end
            OP_LOG: begin
              w0 <= arg_a;
              w2 <= 64'd0;
              e  <= 6'd63;
              st <= I_LNORM;
            end
            OP_ATAN: begin
              if (arg_x == 32'sd0 && arg_y == 32'sd0) begin
                z  <= 32'sd0;
                st <= I_DONE;
              end else if (arg_x[31]) begin
                // fold into the right half plane
                z  <= arg_y[31] ? -ANG180 : ANG180;
                cx <= -ext_x;
                cy <= -ext_y;
                st <= I_ANORM;
              end else begin
                z  <= 32'sd0;
                cx <= ext_x;
                cy <= ext_y;
                st <= I_ANORM;
              end
            end
            default: st <= I_DONE;
          endcase
        end
        I_SQRT: begin
          if (w0 >= trial) begin
            w0 <= w0 - trial;
            w1 <= (w1 >> 1) + w2;
          end else begin
            w1 <= w1 >> 1;
          end
          w2  <= w2 >> 2;
          cnt <= cnt + 7'd1;
          if (cnt == 7'd31) st <= I_DONE;
        end
        I_LNORM: begin
          // shift until the leading one sits at the top
          if (w0[63]) begin
            w1  <= {32'd0, w0[63:32]};
            cnt <= 7'd31;
            st  <= I_LMUL;
          end else begin
            w0 <= w0 << 1;
            e  <= e - 6'd1;
          end
        end
        I_LMUL: st <= I_LSQ;
        I_LSQ: begin
          if (sq[32]) begin
            w1            <= {32'd0, sq[32:1]};
            w2[cnt[4:0]]  <= 1'b1;
          end else begin
            w1 <= {32'd0, sq[31:0]};
          end
          if (cnt == 7'd0) begin
            st <= I_DONE;
          end else begin
            cnt <= cnt - 7'd1;
            st  <= I_LMUL;
          end
        end
        I_ANORM: begin
          if (cx < NORM_MIN && ay < NORM_MIN) begin
            cx <= cx <<< 1;
            cy <= cy <<< 1;
          end else begin
            cnt <= 7'd0;
            st  <= I_ROT;
          end
        end
        I_ROT: begin
          // rotate toward the x axis
          if (!cy[35]) begin
            cx <= cx + sy;
            cy <= cy - sx;
            z  <= z + atan_deg(cnt[4:0]);
          end else begin
            cx <= cx - sy;
            cy <= cy + sx;
            z  <= z - atan_deg(cnt[4:0]);
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'(CORDIC_STEPS - 1)) st <= I_DONE;
        end
        I_DONE: st <= I_IDLE;
        default: st <= I_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/spectrum_bin_postprocess.sv
// Spectrum bin post-processing top level: bin store, frame peak, sequencer.
// Depends on sbp_pkg, sbp_mult and sbp_iter.
//
// A load transaction (tuser = 0) stores one complex bin and updates the frame
// peak power; the input is ready again once the power is summed and the peak
// updated. Writing bin 0 restarts the peak. A read transaction (tuser = 1)
// returns the bin frequency and the value chosen by output_mode. Power
// density, the dB/dBm floors and phase below the peak need no iterative work.
// Magnitude takes 32 square root steps; dB/dBm take a leading-one search,
// 32 squarings and the scaling states S_SCL_LO, S_SCL_HI and S_SCL_SUM;
// phase takes a normalize loop and 24 CORDIC steps, and a zero vector goes
// straight to done. The shared iterative unit resolves one root bit or one
// rotation per cycle and one log bit per pair of multiply and square states;
// a full output register holds the sequencer in S_OUT and so the input. BINS
// must be a power of two: frequency and power density divide by shifting.
// Items with an index at or beyond BINS are dropped. The input is not ready
// while an item is in work; a finished result waits in the output register
// without holding off the next input.
module spectrum_bin_postprocess import sbp_pkg::*; #(
  parameter int BINS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // bin_index[9:0], bin_real[41:10], bin_imag[73:42]
  input  logic [0:0]  s_axis_tuser,  // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // out_index[9:0], bin_frequency_hz[27:10],
                                     // spectrum_value[59:28]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  localparam int AW      = $clog2(BINS);
  localparam int FREQ_SH = AW + 1;
  localparam int PD_SH   = AW + 16;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_RD      = 13'b0000000000010,
    S_SQ_RE   = 13'b0000000000100,
    S_SQ_IM   = 13'b0000000001000,
    S_SUM     = 13'b0000000010000,
    S_FMUL    = 13'b0000000100000,
    S_FREQ    = 13'b0000001000000,
    S_OP_ST   = 13'b0000010000000,
    S_OP      = 13'b0000100000000,
    S_SCL_LO  = 13'b0001000000000,
    S_SCL_HI  = 13'b0010000000000,
    S_SCL_SUM = 13'b0100000000000,
    S_OUT     = 13'b1000000000000
  } state_t;

  state_t             st;
  logic [17:0]        fs;
  logic [2:0]         mode;
  logic [63:0]        peak;
  logic               req;
  logic [9:0]         k;
  logic signed [31:0] re;
  logic signed [31:0] im;
  logic [63:0]        p;
  logic [63:0]        psum;
  logic [17:0]        freq;
  logic [63:0]        lval;
  logic [63:0]        acc;
  logic [31:0]        val;
  logic               out_valid;
  logic [63:0]        out_data;
  logic [63:0]        mem [BINS];
  logic [63:0]        mem_q;

  logic               in_acc;
  logic [9:0]         in_idx;
  logic               idx_ok;
  logic               out_free;
  logic               special;
  mul_req_t           mreq;
  mul_req_t           iter_mreq;
  logic signed [65:0] mprod;
  logic               iter_start;
  iter_op_t           iter_op;
  logic [63:0]        iter_arg;
  logic               iter_done;
  logic [63:0]        iter_res;
  logic [31:0]        sat_res;
  logic [63:0]        fabs;
  logic [63:0]        fq;
  logic [63:0]        pq;
  logic [31:0]        pd_val;
  logic signed [63:0] v;
  logic signed [63:0] t_db;
  logic signed [63:0] t_dbm;
  logic [31:0]        db_val;
  logic [31:0]        dbm_val;

  assign s_axis_tready = (st == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_idx        = s_axis_tdata[9:0];
  assign idx_ok        = {22'd0, in_idx} < 32'(BINS);
  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign psum          = p + mprod[63:0];

  // Values that need no iterative work
  assign special = ((mode == MODE_DB || mode == MODE_DBM) && p == 64'd0) ||
                   (mode == MODE_PHASE && p < peak) || (mode == MODE_PD);

  // Saturate unsigned results to the positive Q16.16 range
  assign sat_res = (iter_res > {32'd0, SAT_MAX}) ? SAT_MAX : iter_res[31:0];
  assign fabs    = mprod[65] ? 64'(-mprod) : mprod[63:0];

  // Divide by 2*BINS and by BINS*2^16 with shifts
  assign fq      = fabs >> FREQ_SH;
  assign pq      = p >> PD_SH;
  assign pd_val  = (pq > {32'd0, SAT_MAX}) ? SAT_MAX : pq[31:0];

  // Scale log2 to dB and dBm with round half up
  always_comb begin
    v       = $signed({mprod[31:0], 32'd0}) + $signed(acc);
    t_db    = v + 64'sh8_0000_0000;
    t_dbm   = v + 64'sh10_0000_0000;
    db_val  = {{4{t_db[63]}}, t_db[63:36]};
    dbm_val = {{5{t_dbm[63]}}, t_dbm[63:37]} + DBM_OFFSET;
  end

  // Route the shared multiplier
  always_comb begin
    case (st)
      S_SQ_RE: begin
        mreq.a = {re[31], re};
        mreq.b = {re[31], re};
      end
      S_SQ_IM: begin
        mreq.a = {im[31], im};
        mreq.b = {im[31], im};
      end
      S_FMUL: begin
        mreq.a = {15'd0, fs};
        mreq.b = {22'd0, k, 1'b0} - 33'(BINS);
      end
      S_SCL_LO: begin
        mreq.a = {1'b0, lval[31:0]};
        mreq.b = {11'd0, DB_COEF_Q20};
      end
      S_SCL_HI: begin
        mreq.a = {{27{lval[37]}}, lval[37:32]};
        mreq.b = {11'd0, DB_COEF_Q20};
      end
      default: mreq = iter_mreq;
    endcase
  end

  // Issue work to the iterative unit
  always_comb begin
    iter_start = (st == S_OP_ST) && !special;
    iter_arg   = p;
    case (mode)
      MODE_DB, MODE_DBM: iter_op = OP_LOG;
      MODE_PHASE:        iter_op = OP_ATAN;
      default:           iter_op = OP_SQRT;
    endcase
  end

  sbp_mult u_mult (
    .clk (clk),
    .req (mreq),
    .p   (mprod)
  );

  sbp_iter u_iter (
    .clk     (clk),
    .rst     (rst),
    .start   (iter_start),
    .op      (iter_op),
    .arg_a   (iter_arg),
    .arg_x   (re),
    .arg_y   (im),
    .mul_p   (mprod),
    .mul_req (iter_mreq),
    .done    (iter_done),
    .result  (iter_res)
  );

  // Bin store: write on load, registered read
  always_ff @(posedge clk) begin
    if (in_acc && idx_ok && !s_axis_tuser[0]) begin
      mem[AW'(in_idx)] <= {s_axis_tdata[73:42], s_axis_tdata[41:10]};
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[AW'(in_idx)];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fs   <= FS_RESET;
      mode <= MODE_MAG;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_RATE: fs   <= cfg_data;
        CFG_OUTPUT_MODE: mode <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_OUT && out_free) begin
      out_data <= {4'd0, val, freq, k};
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      peak <= 64'd0;
    end else begin
      case (st)
        S_IDLE: if (in_acc && idx_ok) begin
          req <= s_axis_tuser[0];
          k   <= in_idx;
          re  <= s_axis_tdata[41:10];
          im  <= s_axis_tdata[73:42];
          st  <= s_axis_tuser[0] ? S_RD : S_SQ_RE;
        end
        S_RD: begin
          re <= mem_q[31:0];
          im <= mem_q[63:32];
          st <= S_SQ_RE;
        end
        S_SQ_RE: st <= S_SQ_IM;
        S_SQ_IM: begin
          p  <= mprod[63:0];
          st <= S_SUM;
        end
        S_SUM: begin
          p <= psum;
          if (req) begin
            st <= S_FMUL;
          end else begin
            // bin 0 opens a new frame
            if (k == 10'd0 || psum > peak) peak <= psum;
            st <= S_IDLE;
          end
        end
        S_FMUL: st <= S_FREQ;
        S_FREQ: begin
          // truncate toward zero
          freq <= mprod[65] ? -fq[17:0] : fq[17:0];
          st   <= S_OP_ST;
        end
        S_OP_ST: begin
          if (special) begin
            case (mode)
              MODE_DB:  val <= DB_FLOOR;
              MODE_DBM: val <= DBM_FLOOR;
              MODE_PD:  val <= pd_val;
              default:  val <= 32'd0;
            endcase
            st <= S_OUT;
          end else begin
            st <= S_OP;
          end
        end
        S_OP: if (iter_done) begin
          case (mode)
            MODE_DB, MODE_DBM: begin
              lval <= iter_res;
              st   <= S_SCL_LO;
            end
            MODE_PHASE: begin
              val <= iter_res[31:0];
              st  <= S_OUT;
            end
            default: begin
              val <= sat_res;
              st  <= S_OUT;
            end
          endcase
        end
        S_SCL_LO: st <= S_SCL_HI;
        S_SCL_HI: begin
          acc <= mprod[63:0];
          st  <= S_SCL_SUM;
        end
        S_SCL_SUM: begin
          val <= (mode == MODE_DB) ? db_val : dbm_val;
          st  <= S_OUT;
        end
        S_OUT: if (out_free) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/spectrum_bin_postprocess_test.sv
// Self-checking testbench for spectrum_bin_postprocess: bin loads, reads in every
// output mode, checked against an in-bench predictor. Depends on sbp_pkg and the RTL.
module spectrum_bin_postprocess_test import sbp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBINS = 1024;
  localparam int SETTLE = 300;

  typedef struct {
    logic [9:0]  idx;
    logic [17:0] freq;
    logic [31:0] value;
  } bin_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // bin_index[9:0], bin_real[41:10], bin_imag[73:42]
  logic [0:0]  s_axis_tuser = '0;  // req_type[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;       // out_index[9:0], bin_frequency_hz[27:10],
                                   // spectrum_value[59:28]
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;

  // predictor state
  logic [63:0] bin_mem [NBINS];
  bit          bin_written [NBINS];
  logic [63:0] peak_power;
  logic [17:0] fs_hz;
  logic [2:0]  out_mode;

  bin_result_t expected_bins[$];
  int          idle_pct;
  int          stall_pct;
  int          errors;

  spectrum_bin_postprocess u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Power re^2 + im^2, exact
  function automatic logic [63:0] power_of(logic signed [31:0] re, logic signed [31:0] im);
    longint r, i;
    r = re;
    i = im;
    return 64'(r * r) + 64'(i * i);
  endfunction

  function automatic longint log2_q32(logic [63:0] p);
    int e;
    logic [63:0] m;
    longint frac;
    e = 63;
    frac = 0;
    while (p[e] == 1'b0) e--;
    m = (e >= 31) ? (p >> (e - 31)) : (p << (31 - e));
    for (int i = 31; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac = frac | (longint'(1) << i);
      end
    end
    return longint'(e - 32) * 64'sh1_0000_0000 + frac;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint phase_deg(longint x, longint y);
    longint z, ax, ay, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? (longint'(180) <<< 16) : -(longint'(180) <<< 16);
      x = -x;
      y = -y;
    end
    ax = x;
    ay = (y < 0) ? -y : y;
    while (ax < (longint'(1) <<< 30) && ay < (longint'(1) <<< 30)) begin
      x = x * 2; y = y * 2; ax = ax * 2; ay = ay * 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + longint'(atan_deg(5'(i)));
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - longint'(atan_deg(5'(i)));
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  // Work out the result of a read of bin k
  function automatic bin_result_t bin_readout(int k);
    bin_result_t res;
    logic signed [31:0] re, im;
    logic [63:0] p, t;
    longint fs, freq, v;
    re = bin_mem[k][31:0];
    im = bin_mem[k][63:32];
    p = power_of(re, im);
    fs = fs_hz;
    freq = (2 * longint'(k) * fs - longint'(NBINS) * fs) / (2 * NBINS);
    case (out_mode)
      MODE_DB: begin
        if (p == 0) v = DB_FLOOR;
        else v = (log2_q32(p) * 3156528 + (longint'(1) <<< 35)) >>> 36;
      end
      MODE_DBM: begin
        if (p == 0) v = DBM_FLOOR;
        else v = DBM_OFFSET + ((log2_q32(p) * 3156528 + (longint'(1) <<< 36)) >>> 37);
      end
      MODE_PD: begin
        t = p / (64'(NBINS) << 16);
        v = (t > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : t;
      end
      MODE_PHASE: v = (p < peak_power) ? 0 : phase_deg(longint'(re), longint'(im));
      default: begin
        t = int_sqrt(p);
        v = (t > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : t;
      end
    endcase
    res.idx = 10'(k);
    res.freq = 18'(freq);
    res.value = 32'(v);
    return res;
  endfunction

  // Send one request; predict at the accepting edge
  task automatic send_item(bit rd, int k, logic [31:0] re, logic [31:0] im);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= rd;
    s_axis_tdata <= {6'b0, im, re, 10'(k)};
    do @(posedge clk); while (!s_axis_tready);
    if (rd) begin
      expected_bins.push_back(bin_readout(k));
    end else begin
      bin_mem[k] = {im, re};
      bin_written[k] = 1'b1;
      if (k == 0 || power_of(re, im) > peak_power) peak_power = power_of(re, im);
    end
  endtask

  // Hold input until every result is back and the block has settled
  task automatic drain;
    @(posedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [17:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SAMPLE_RATE) fs_hz = value;
    else out_mode = value[2:0];
  endtask

  function automatic logic [31:0] rand_part();
    case ($urandom_range(3))
      0: return 32'($urandom_range(255)) - 32'd128;
      1: return 32'($urandom_range(32'h3_0000)) - 32'h1_8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int written_bin();
    int k;
    do k = $urandom_range(NBINS - 1); while (!bin_written[k]);
    return k;
  endfunction

  // Extremes of the bin values, all modes, zero magnitude, phase below peak
  task automatic test_directed;
    send_item(0, 0, 32'h0, 32'h0);
    send_item(0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(0, 2, 32'h8000_0000, 32'h8000_0000);
    send_item(0, 1023, 32'h0001_0000, 32'hFFFF_0000);
    send_item(0, 3, 32'hFFFF_FFFF, 32'h0000_0001);
    for (int m = 0; m < 8; m++) begin
      drain();
      write_cfg(CFG_OUTPUT_MODE, 18'(m));
      send_item(1, 0, 0, 0);
      send_item(1, 2, 0, 0);
      send_item(1, (m % 2) ? 1023 : 3, 0, 0);
    end
    drain();
    write_cfg(CFG_SAMPLE_RATE, 18'd1);
    send_item(1, 1, $urandom, $urandom);
    drain();
    write_cfg(CFG_SAMPLE_RATE, 18'd192000);
    send_item(1, 1023, $urandom, $urandom);
  endtask

  // Frames of random bins, reading only bins that were loaded
  task automatic test_random(int n_items);
    int k;
    for (int blk = 0; blk < n_items / 50; blk++) begin
      drain();
      case ($urandom_range(3))
        0: write_cfg(CFG_SAMPLE_RATE, 18'd1);
        1: write_cfg(CFG_SAMPLE_RATE, 18'd192000);
        default: write_cfg(CFG_SAMPLE_RATE, 18'($urandom_range(192000, 1)));
      endcase
      write_cfg(CFG_OUTPUT_MODE, 18'($urandom_range(7)));
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(19) == 0) send_item(0, 0, rand_part(), rand_part());
        else if ($urandom_range(1)) send_item(1, written_bin(), $urandom, $urandom);
        else begin
          k = $urandom_range(NBINS - 1);
          send_item(0, k, rand_part(), rand_part());
        end
      end
    end
  endtask

  // Receiver: random stall, compare each result transaction
  always @(posedge clk) begin
    bin_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bins.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          want = expected_bins.pop_front();
          if (m_axis_tdata[9:0] !== want.idx || m_axis_tdata[27:10] !== want.freq ||
              m_axis_tdata[59:28] !== want.value) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp idx %0d freq %h val %h, got idx %0d freq %h val %h",
                       want.idx, want.freq, want.value, m_axis_tdata[9:0],
                       m_axis_tdata[27:10], m_axis_tdata[59:28]);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    peak_power = 0;
    fs_hz = FS_RESET;
    out_mode = MODE_MAG;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    idle_pct = 69; stall_pct = 0;
    test_random(150);
    idle_pct = 0; stall_pct = 69;
    test_random(150);
    idle_pct = 28; stall_pct = 28;
    test_random(150);
    idle_pct = 0; stall_pct = 0;
    test_random(150);
    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #4ms;
    $display("status: fail");
    $finish;
  end
endmodule

// File: spectrum_bin_postprocess.f
rtl/core/sbp_pkg.sv
rtl/core/sbp_mult.sv
rtl/core/sbp_iter.sv
rtl/core/spectrum_bin_postprocess.sv
tb/spectrum_bin_postprocess_test.sv
